// ===== rtl/efws_pkg.sv =====
// Shared types and constants for the earliest-free worker scheduler.
// Used by efws_ctrl, efws_dp and earliest_free_worker_scheduler_top.
// No dependencies.
package efws_pkg;

  // Worker pool sizing.
  localparam int MAX_WORKERS = 16;
  localparam int WID_W       = $clog2(MAX_WORKERS);
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int HALF        = MAX_WORKERS / 2;
  localparam int LEVELS      = WID_W;
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Payload widths.
  localparam int DUR_W   = 32;
  localparam int TIME_W  = 64;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 72;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int NW_W   = 5;
  localparam logic [0:0] REG_NUM_WORKERS = 1'b0;
  localparam logic [NW_W-1:0] NW_RESET = NW_W'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // latch a new job and snapshot the worker count
    logic search;        // run one level of the min-reduction tree
    logic search_first;  // this level reads the finish-time registers
    logic commit;        // update the chosen worker and load the output
  } efws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic direct;    // the next job goes to a worker not used yet
    logic out_free;  // the output register can take a result this cycle
  } efws_sts_t;

endpackage

// ===== rtl/efws_ctrl.sv =====
// Controller state machine for the earliest-free worker scheduler.
// Depends on efws_pkg; drives efws_dp through efws_cmd_t.
module efws_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  efws_pkg::efws_sts_t  sts,
  output efws_pkg::efws_cmd_t  cmd
);
  import efws_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    level_next = level;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          level_next = '0;
          state_next = sts.direct ? ST_COMMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search       = 1'b1;
        cmd.search_first = (level == '0);
        level_next       = level + LVL_W'(1);
        if (level == LVL_W'(LEVELS - 1)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
    end
  end

endmodule

// ===== rtl/efws_dp.sv =====
// Datapath for the earliest-free worker scheduler: finish times, job count,
// registered min-reduction tree and output register. Depends on efws_pkg.
module efws_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  efws_pkg::efws_cmd_t               cmd,
  output efws_pkg::efws_sts_t               sts,
  input  logic [efws_pkg::DUR_W-1:0]        job_duration,
  input  logic [efws_pkg::NW_W-1:0]         num_workers,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [efws_pkg::WID_W-1:0]        assigned_worker,
  output logic [efws_pkg::TIME_W-1:0]       job_start
);
  import efws_pkg::*;

  logic [TIME_W-1:0] finish_times [MAX_WORKERS];
  logic [CNT_W-1:0]  jobs_started;
  logic [DUR_W-1:0]  dur;
  logic [CNT_W-1:0]  n_act;
  logic              direct;
  logic [WID_W-1:0]  direct_idx;

  // Tree candidates, reduced in place one level per cycle.
  logic [TIME_W-1:0] cand_time [HALF];
  logic [WID_W-1:0]  cand_idx  [HALF];
  logic              cand_vld  [HALF];

  logic [TIME_W-1:0] src_time [MAX_WORKERS];
  logic [WID_W-1:0]  src_idx  [MAX_WORKERS];
  logic              src_vld  [MAX_WORKERS];
  logic [TIME_W-1:0] cand_time_next [HALF];
  logic [WID_W-1:0]  cand_idx_next  [HALF];
  logic              cand_vld_next  [HALF];

  logic [CNT_W-1:0]  n_live;
  logic [WID_W-1:0]  sel;
  logic [TIME_W-1:0] sel_time;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] finish_next;

  // Clamp the configured worker count into 1..MAX_WORKERS.
  always_comb begin
    if (num_workers == '0) begin
      n_live = CNT_W'(1);
    end else if (CNT_W'(num_workers) > CNT_W'(MAX_WORKERS)) begin
      n_live = CNT_W'(MAX_WORKERS);
    end else begin
      n_live = CNT_W'(num_workers);
    end
  end

  assign sts.direct   = (jobs_started < n_live);
  assign sts.out_free = !m_tvalid || m_tready;

  // Sources of one tree level: the finish times on the first level, else
  // the surviving candidates.
  always_comb begin
    for (int j = 0; j < MAX_WORKERS; j++) begin
      if (cmd.search_first) begin
        src_time[j] = finish_times[j];
        src_idx[j]  = WID_W'(j);
        src_vld[j]  = (CNT_W'(j) < n_act);
      end else if (j < HALF) begin
        src_time[j] = cand_time[j];
        src_idx[j]  = cand_idx[j];
        src_vld[j]  = cand_vld[j];
      end else begin
        src_time[j] = '0;
        src_idx[j]  = '0;
        src_vld[j]  = 1'b0;
      end
    end
  end

  // Pairwise pick; the higher index wins only when strictly earlier.
  always_comb begin
    for (int i = 0; i < HALF; i++) begin
      if (src_vld[2*i+1] &&
          (!src_vld[2*i] || (src_time[2*i+1] < src_time[2*i]))) begin
        cand_time_next[i] = src_time[2*i+1];
        cand_idx_next[i]  = src_idx[2*i+1];
        cand_vld_next[i]  = 1'b1;
      end else begin
        cand_time_next[i] = src_time[2*i];
        cand_idx_next[i]  = src_idx[2*i];
        cand_vld_next[i]  = src_vld[2*i];
      end
    end
  end

  // Chosen worker and its saturating finish-time update.
  assign sel         = direct ? direct_idx : cand_idx[0];
  assign sel_time    = finish_times[sel];
  assign sum         = {1'b0, sel_time} + (TIME_W+1)'(dur);
  assign finish_next = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  // Job snapshot and tree registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur        <= job_duration;
      n_act      <= n_live;
      direct     <= sts.direct;
      direct_idx <= jobs_started[WID_W-1:0];
    end
    if (cmd.search) begin
      for (int i = 0; i < HALF; i++) begin
        cand_time[i] <= cand_time_next[i];
        cand_idx[i]  <= cand_idx_next[i];
        cand_vld[i]  <= cand_vld_next[i];
      end
    end
  end

  // Worker state, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      jobs_started <= '0;
      for (int k = 0; k < MAX_WORKERS; k++) begin
        finish_times[k] <= '0;
      end
    end else if (cmd.commit) begin
      finish_times[sel] <= finish_next;
      if (direct) begin
        jobs_started <= jobs_started + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      assigned_worker <= sel;
      job_start       <= sel_time;
    end
  end

endmodule

// ===== rtl/earliest_free_worker_scheduler_top.sv =====
// Earliest-free worker scheduler: one result per job, through efws_ctrl
// and efws_dp, with the worker-count register on an APB-style port.
// While unused workers remain, a job is latched on acceptance and then committed
// straight to the output register, with no tree search. Otherwise it is latched,
// searched through the levels of the registered min-reduction tree over 16
// finish times and then committed. A busy output register holds the commit back.
// Synchronous reset clears all finish times, the job count, the output valid and
// sets num_workers to 1.
module earliest_free_worker_scheduler_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [efws_pkg::S_DATA_W-1:0]    s_tdata,  // [31:0] job_duration
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [efws_pkg::M_DATA_W-1:0]    m_tdata,  // [3:0] assigned_worker,
                                                     // [67:4] job start, zero pad
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [efws_pkg::ADDR_W-1:0]      paddr,
  input  logic [efws_pkg::DATA_W-1:0]      pwdata,
  output logic [efws_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import efws_pkg::*;

  efws_cmd_t         cmd;
  efws_sts_t         sts;
  logic [NW_W-1:0]   num_workers;
  logic [WID_W-1:0]  assigned_worker;
  logic [TIME_W-1:0] job_start;
  logic              wr_en;

  // Configuration register access.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1] == REG_NUM_WORKERS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_workers <= NW_RESET;
    end else if (wr_en) begin
      num_workers <= pwdata[NW_W-1:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1] == REG_NUM_WORKERS) begin
      prdata = DATA_W'(num_workers);
    end else begin
      prdata = '0;
    end
  end

  efws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  efws_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .job_duration    (s_tdata[DUR_W-1:0]),
    .num_workers     (num_workers),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .assigned_worker (assigned_worker),
    .job_start       (job_start)
  );

  // Pack the result transaction.
  assign m_tdata = {(M_DATA_W - WID_W - TIME_W)'(0), job_start, assigned_worker};

`ifndef SYNTHESIS
  // One job in flight: no second transaction right after an accepted one.
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted back to back");

  // A commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result committed into a full output register");

  // Every commit shows up as a valid result in the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

  // Load never coincides with commit or search.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && (cmd.commit || cmd.search)))
    else $error("conflicting datapath commands");
`endif

endmodule
